>>> src/rtpa_pkg.sv
// shared types, constants and tables for the rssi table power average block
`default_nettype none

package rtpa_pkg;

    localparam int STATIONS = 16;
    localparam int SAMPLES  = 8;

    localparam int ROW_W   = $clog2(STATIONS);
    localparam int SLOT_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int CNT_W   = $clog2(SAMPLES + 1);
    localparam int SADDR_W = ROW_W + SLOT_W;
    localparam int SDEPTH  = STATIONS * (2 ** SLOT_W);

    localparam int MAC_W  = 48;
    localparam int RSSI_W = 8;
    localparam int TIME_W = 32;
    localparam int AVG_W  = 12;

    localparam int P_W     = 21;
    localparam int SUM_W   = P_W + $clog2(SAMPLES);
    localparam int V_W     = 21;
    localparam int K_W     = 5;
    localparam int F_W     = 16;
    localparam int L_W     = 21;
    localparam int DB_W    = 22;
    localparam int PROD_W  = L_W + DB_W;
    localparam int RES_W   = 14;
    localparam int P_TAB_N = 70;

    localparam logic [DB_W-1:0] DB_PER_LOG2 = 22'd3156528;

    localparam logic [0:9][P_W-1:0] TEN_POW = '{
        21'd1048576, 21'd832914, 21'd661607, 21'd525533, 21'd417446,
        21'd331589, 21'd263390, 21'd209218, 21'd166188, 21'd132008
    };

    typedef logic [0:P_TAB_N-1][P_W-1:0] t_ptab;

    // relative power for a gap of d dB below the strongest sample
    function automatic t_ptab make_ptab();
        t_ptab       tab;
        logic [31:0] v;
        for (int d = 0; d < P_TAB_N; d++) begin
            v = 32'(TEN_POW[d % 10]);
            for (int q = 0; q < d / 10; q++) begin
                v = v / 10;
            end
            tab[d] = v[P_W-1:0];
        end
        return tab;
    endfunction

    localparam t_ptab P_TAB = make_ptab();

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_PURGE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [MAC_W-1:0]         station_mac;
        logic signed [RSSI_W-1:0] rssi_dbm;
        logic [TIME_W-1:0]        expiry_time;
        logic [TIME_W-1:0]        present_time;
    } t_in;

    typedef struct packed {
        logic                    found;
        logic signed [AVG_W-1:0] average_dbm_q4;
        logic [3:0]              sample_count;
        logic [1:0]              status;
    } t_out;

    typedef struct packed {
        logic signed [RSSI_W-1:0] rssi;
        logic [TIME_W-1:0]        expiry;
    } t_sample;

    localparam int SAMP_W = $bits(t_sample);

    typedef struct packed {
        logic                     start;
        logic [SUM_W-1:0]         sum;
        logic [CNT_W-1:0]         n;
        logic signed [RSSI_W-1:0] m;
    } t_avg_req;

    typedef struct packed {
        logic                    done;
        logic signed [AVG_W-1:0] avg;
    } t_avg_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_DISPATCH,
        S_ADD,
        S_QMAX,
        S_QSUM,
        S_QWAIT,
        S_PSCAN,
        S_PWRITE,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        L_IDLE,
        L_DIV,
        L_NORM,
        L_LOG,
        L_MUL,
        L_FIN
    } t_lstate;

endpackage

`default_nettype wire

>>> src/rtpa_ram.sv
// generic single write port ram with registered read
`default_nettype none

module rtpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> src/rtpa_log.sv
// mean power divide, normalize, log2 and scale to 1/16 dB
`default_nettype none

module rtpa_log (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rtpa_pkg::t_avg_req i_req,
    output rtpa_pkg::t_avg_rsp      o_rsp
);

    localparam int C_W = $clog2(rtpa_pkg::SUM_W + 1);

    rtpa_pkg::t_lstate r_state, n_state;

    logic [rtpa_pkg::SUM_W-1:0]         r_q;
    logic [rtpa_pkg::CNT_W-1:0]         r_rem, r_n;
    logic [C_W-1:0]                     r_c;
    logic [rtpa_pkg::V_W-1:0]           r_v;
    logic [rtpa_pkg::K_W-1:0]           r_k;
    logic [rtpa_pkg::F_W-1:0]           r_f;
    logic [rtpa_pkg::PROD_W-1:0]        r_prod;
    logic signed [rtpa_pkg::RSSI_W-1:0] r_m;
    logic                               r_done;
    logic signed [rtpa_pkg::AVG_W-1:0]  r_avg;

    logic [rtpa_pkg::CNT_W:0]       div_t;
    logic                           div_ge;
    logic [rtpa_pkg::V_W-1:0]       v_init;
    logic [2*rtpa_pkg::V_W-1:0]     sq;
    logic [rtpa_pkg::V_W:0]         sq_q20;
    logic [rtpa_pkg::L_W-1:0]       l_val;
    logic [rtpa_pkg::PROD_W:0]      rounded;
    logic [rtpa_pkg::AVG_W-1:0]     off;
    logic signed [rtpa_pkg::RES_W-1:0] res;

    assign div_t  = {r_rem, r_q[rtpa_pkg::SUM_W-1]};
    assign div_ge = div_t >= {1'b0, r_n};
    assign sq     = r_v * r_v;
    assign sq_q20 = sq[2*rtpa_pkg::V_W-1:20];
    assign l_val  = {r_k, 16'd0} - rtpa_pkg::L_W'(r_f);
    assign rounded = {1'b0, r_prod} + (rtpa_pkg::PROD_W + 1)'(64'd2147483648);
    assign off    = rounded[rtpa_pkg::PROD_W:32];
    assign res    = (rtpa_pkg::RES_W'(r_m) <<< 4) - $signed({2'b00, off});

    always_comb begin
        if (r_q == '0) begin
            v_init = rtpa_pkg::V_W'(1);
        end else if (r_q >= rtpa_pkg::SUM_W'(2 ** rtpa_pkg::V_W)) begin
            v_init = '1;
        end else begin
            v_init = r_q[rtpa_pkg::V_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rtpa_pkg::L_IDLE: if (i_req.start) n_state = rtpa_pkg::L_DIV;
            rtpa_pkg::L_DIV:  if (r_c == C_W'(rtpa_pkg::SUM_W - 1)) n_state = rtpa_pkg::L_NORM;
            rtpa_pkg::L_NORM: if (r_c == '0 && r_v[rtpa_pkg::V_W-1]) n_state = rtpa_pkg::L_LOG;
            rtpa_pkg::L_LOG:  if (r_c == C_W'(rtpa_pkg::F_W - 1)) n_state = rtpa_pkg::L_MUL;
            rtpa_pkg::L_MUL:  n_state = rtpa_pkg::L_FIN;
            rtpa_pkg::L_FIN:  n_state = rtpa_pkg::L_IDLE;
            default:          n_state = rtpa_pkg::L_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.done = r_done;
        o_rsp.avg  = r_avg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rtpa_pkg::L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == rtpa_pkg::L_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            rtpa_pkg::L_IDLE: begin
                r_q   <= i_req.sum;
                r_n   <= i_req.n;
                r_m   <= i_req.m;
                r_rem <= '0;
                r_c   <= '0;
            end
            rtpa_pkg::L_DIV: begin
                if (div_ge) begin
                    r_rem <= rtpa_pkg::CNT_W'(div_t - {1'b0, r_n});
                    r_q   <= {r_q[rtpa_pkg::SUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= div_t[rtpa_pkg::CNT_W-1:0];
                    r_q   <= {r_q[rtpa_pkg::SUM_W-2:0], 1'b0};
                end
                r_c <= r_c + C_W'(1);
                r_k <= '0;
            end
            rtpa_pkg::L_NORM: begin
                if (r_c != '0) begin
                    r_v <= v_init;
                    r_c <= '0;
                end else if (!r_v[rtpa_pkg::V_W-1]) begin
                    r_v <= {r_v[rtpa_pkg::V_W-2:0], 1'b0};
                    r_k <= r_k + rtpa_pkg::K_W'(1);
                end
                r_f <= '0;
            end
            rtpa_pkg::L_LOG: begin
                if (sq_q20[rtpa_pkg::V_W]) begin
                    r_v <= sq_q20[rtpa_pkg::V_W:1];
                    r_f <= {r_f[rtpa_pkg::F_W-2:0], 1'b1};
                end else begin
                    r_v <= sq_q20[rtpa_pkg::V_W-1:0];
                    r_f <= {r_f[rtpa_pkg::F_W-2:0], 1'b0};
                end
                r_c <= r_c + C_W'(1);
            end
            rtpa_pkg::L_MUL: begin
                r_prod <= l_val * rtpa_pkg::DB_PER_LOG2;
            end
            rtpa_pkg::L_FIN: begin
                if (res > 0) begin
                    r_avg <= '0;
                end else if (res < -2048) begin
                    r_avg <= rtpa_pkg::AVG_W'(-2048);
                end else begin
                    r_avg <= res[rtpa_pkg::AVG_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/rssi_table_power_average.sv
// top level: station table, sample store and step sequencer
//
// one input channel and one output channel, both valid/ready; every accepted
// input beat produces exactly one output beat
// a step first scans the station mac memory one row per cycle, then:
//   add    writes the new sample into its ring slot and updates the count
//          and ring head in the S_ADD state
//   purge  reads the ring, then writes the kept samples back
//   query  scans the sample memory twice, for the strongest sample and then
//          for the summed relative power, then runs the log unit: serial
//          divide, normalize, 16 squaring steps, scale and clamp
// the sample memory's single read port and the serial divider and squaring
// loop set the length of a step
// one step is in flight at a time; the next input beat is taken as soon as
// the result sits in the output register, even if it is not yet taken
// when the receiver stalls the finished result waits in a state of its own
// reset clears the station valid bits, counts and ring heads; the memories
// hold no meaning until written
`default_nettype none

module rssi_table_power_average (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire rtpa_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output rtpa_pkg::t_out      o_out_data
);

    localparam int AW = rtpa_pkg::SLOT_W + 1;

    rtpa_pkg::t_state r_state, n_state;
    rtpa_pkg::t_in    r_in;
    rtpa_pkg::t_out   r_res, r_out;
    logic             r_out_valid;

    logic [rtpa_pkg::STATIONS-1:0] r_sv;
    logic [rtpa_pkg::CNT_W-1:0]    r_cnt [rtpa_pkg::STATIONS];
    logic [rtpa_pkg::SLOT_W-1:0]   r_old [rtpa_pkg::STATIONS];

    logic [rtpa_pkg::ROW_W:0]   r_idx;
    logic [rtpa_pkg::ROW_W-1:0] r_pidx, r_row, r_free_row;
    logic                       r_pend, r_hit, r_free_ok;
    logic [rtpa_pkg::CNT_W-1:0] r_n, r_j, r_kept;
    logic [rtpa_pkg::SLOT_W-1:0] r_oq;
    logic signed [rtpa_pkg::RSSI_W-1:0] r_m;
    logic [rtpa_pkg::SUM_W-1:0] r_sum;
    rtpa_pkg::t_sample          r_buf [rtpa_pkg::SAMPLES];

    logic                         mac_we;
    logic [rtpa_pkg::MAC_W-1:0]   mac_rdata;
    logic                         samp_we;
    logic [rtpa_pkg::SADDR_W-1:0] samp_waddr, samp_raddr;
    logic [rtpa_pkg::SAMP_W-1:0]  samp_wdata, samp_rdata;
    rtpa_pkg::t_sample            rd_s;

    rtpa_pkg::t_avg_req avg_req;
    rtpa_pkg::t_avg_rsp avg_rsp;
    rtpa_pkg::t_out     disp_res;

    logic accept, out_load, scan_more, scan_end, search_end;
    logic [rtpa_pkg::ROW_W-1:0]  rowsel;
    logic                        a_full;
    logic [rtpa_pkg::CNT_W-1:0]  a_n, a_cnt_nx;
    logic [rtpa_pkg::SLOT_W-1:0] a_o, a_slot, a_old_nx, j_slot;
    logic [AW-1:0]               a_sum, j_sum;
    logic signed [rtpa_pkg::RSSI_W:0] dd;
    logic [rtpa_pkg::P_W-1:0]    p_val;

    assign accept     = i_in_valid && o_in_ready;
    assign out_load   = (r_state == rtpa_pkg::S_DONE) && (!r_out_valid || i_out_ready);
    assign scan_more  = r_j < r_n;
    assign scan_end   = !scan_more && !r_pend;
    assign search_end = (r_idx == (rtpa_pkg::ROW_W + 1)'(rtpa_pkg::STATIONS)) && !r_pend;
    assign rowsel     = r_hit ? r_row : r_free_row;
    assign rd_s       = rtpa_pkg::t_sample'(samp_rdata);

    // add: slot to write and new ring state; scans: ring slot to read, dB gap and its relative power
    always_comb begin
        a_n   = r_hit ? r_cnt[r_row] : '0;
        a_o   = r_hit ? r_old[r_row] : '0;
        a_full = a_n == rtpa_pkg::CNT_W'(rtpa_pkg::SAMPLES);
        a_sum = AW'(a_o) + AW'(a_n);
        if (a_full) begin
            a_slot   = a_o;
            a_old_nx = (a_o == rtpa_pkg::SLOT_W'(rtpa_pkg::SAMPLES - 1)) ? '0
                                                                         : a_o + 1'b1;
            a_cnt_nx = a_n;
        end else begin
            a_slot   = (a_sum >= AW'(rtpa_pkg::SAMPLES))
                       ? rtpa_pkg::SLOT_W'(a_sum - AW'(rtpa_pkg::SAMPLES))
                       : a_sum[rtpa_pkg::SLOT_W-1:0];
            a_old_nx = a_o;
            a_cnt_nx = a_n + 1'b1;
        end
        j_sum  = AW'(r_oq) + AW'(r_j[rtpa_pkg::SLOT_W-1:0]);
        j_slot = (j_sum >= AW'(rtpa_pkg::SAMPLES))
                 ? rtpa_pkg::SLOT_W'(j_sum - AW'(rtpa_pkg::SAMPLES))
                 : j_sum[rtpa_pkg::SLOT_W-1:0];
        dd     = $signed({r_m[rtpa_pkg::RSSI_W-1], r_m})
               - $signed({rd_s.rssi[rtpa_pkg::RSSI_W-1], rd_s.rssi});
        p_val  = (dd[rtpa_pkg::RSSI_W-1:0] < 8'(rtpa_pkg::P_TAB_N))
                 ? rtpa_pkg::P_TAB[dd[6:0]] : '0;
    end

    // early result for steps that end at dispatch
    always_comb begin
        disp_res = '0;
        unique case (rtpa_pkg::t_op'(r_in.opcode))
            rtpa_pkg::OP_ADD: begin
                if (!r_hit && !r_free_ok) disp_res.status = rtpa_pkg::ST_FULL;
            end
            rtpa_pkg::OP_QUERY: begin
                if (!r_hit) begin
                    disp_res.status = rtpa_pkg::ST_UNKNOWN;
                end else if (r_cnt[r_row] == '0) begin
                    disp_res.status = rtpa_pkg::ST_EMPTY;
                    disp_res.found  = 1'b1;
                end
            end
            rtpa_pkg::OP_PURGE: begin
                if (!r_hit) disp_res.status = rtpa_pkg::ST_UNKNOWN;
            end
            rtpa_pkg::OP_NONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rtpa_pkg::S_IDLE:   if (accept) n_state = rtpa_pkg::S_SEARCH;
            rtpa_pkg::S_SEARCH: if (search_end) n_state = rtpa_pkg::S_DISPATCH;
            rtpa_pkg::S_DISPATCH: begin
                unique case (rtpa_pkg::t_op'(r_in.opcode))
                    rtpa_pkg::OP_ADD:
                        n_state = (r_hit || r_free_ok) ? rtpa_pkg::S_ADD : rtpa_pkg::S_DONE;
                    rtpa_pkg::OP_QUERY:
                        n_state = (r_hit && r_cnt[r_row] != '0) ? rtpa_pkg::S_QMAX
                                                                : rtpa_pkg::S_DONE;
                    rtpa_pkg::OP_PURGE:
                        n_state = r_hit ? rtpa_pkg::S_PSCAN : rtpa_pkg::S_DONE;
                    rtpa_pkg::OP_NONE:
                        n_state = rtpa_pkg::S_DONE;
                    default:
                        n_state = rtpa_pkg::S_DONE;
                endcase
            end
            rtpa_pkg::S_ADD:    n_state = rtpa_pkg::S_DONE;
            rtpa_pkg::S_QMAX:   if (scan_end) n_state = rtpa_pkg::S_QSUM;
            rtpa_pkg::S_QSUM:   if (scan_end) n_state = rtpa_pkg::S_QWAIT;
            rtpa_pkg::S_QWAIT:  if (avg_rsp.done) n_state = rtpa_pkg::S_DONE;
            rtpa_pkg::S_PSCAN:  if (scan_end) n_state = rtpa_pkg::S_PWRITE;
            rtpa_pkg::S_PWRITE: if (r_j >= r_kept) n_state = rtpa_pkg::S_DONE;
            rtpa_pkg::S_DONE:   if (out_load) n_state = rtpa_pkg::S_IDLE;
            default:            n_state = rtpa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == rtpa_pkg::S_IDLE);
        o_out_valid   = r_out_valid;
        o_out_data    = r_out;
        mac_we        = (r_state == rtpa_pkg::S_ADD) && !r_hit;
        samp_raddr    = {r_row, j_slot};
        samp_we       = 1'b0;
        samp_waddr    = {r_row, a_slot};
        samp_wdata    = {r_in.rssi_dbm, r_in.expiry_time};
        if (r_state == rtpa_pkg::S_ADD) begin
            samp_we = 1'b1;
        end else if (r_state == rtpa_pkg::S_PWRITE && r_j < r_kept) begin
            samp_we    = 1'b1;
            samp_waddr = {r_row, r_j[rtpa_pkg::SLOT_W-1:0]};
            samp_wdata = r_buf[r_j[rtpa_pkg::SLOT_W-1:0]];
        end
        avg_req.start = (r_state == rtpa_pkg::S_QSUM) && scan_end;
        avg_req.sum   = r_sum;
        avg_req.n     = r_n;
        avg_req.m     = r_m;
    end

    rtpa_ram #(
        .WIDTH (rtpa_pkg::MAC_W),
        .DEPTH (rtpa_pkg::STATIONS)
    ) u_mac_ram (
        .i_clk   (i_clk),
        .i_we    (mac_we),
        .i_waddr (r_row),
        .i_wdata (r_in.station_mac),
        .i_raddr (r_idx[rtpa_pkg::ROW_W-1:0]),
        .o_rdata (mac_rdata)
    );

    rtpa_ram #(
        .WIDTH (rtpa_pkg::SAMP_W),
        .DEPTH (rtpa_pkg::SDEPTH)
    ) u_samp_ram (
        .i_clk   (i_clk),
        .i_we    (samp_we),
        .i_waddr (samp_waddr),
        .i_wdata (samp_wdata),
        .i_raddr (samp_raddr),
        .o_rdata (samp_rdata)
    );

    rtpa_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (avg_req),
        .o_rsp   (avg_rsp)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rtpa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_sv        <= '0;
            for (int s = 0; s < rtpa_pkg::STATIONS; s++) begin
                r_cnt[s] <= '0;
                r_old[s] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == rtpa_pkg::S_ADD) begin
                r_sv[r_row]  <= 1'b1;
                r_cnt[r_row] <= a_cnt_nx;
                r_old[r_row] <= a_old_nx;
            end
            if (r_state == rtpa_pkg::S_PWRITE && r_j >= r_kept) begin
                r_cnt[r_row] <= r_kept;
                r_old[r_row] <= '0;
            end
        end
    end

    // step datapath
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_res;
        end
        case (r_state)
            rtpa_pkg::S_IDLE: begin
                r_in      <= i_in_data;
                r_idx     <= '0;
                r_pend    <= 1'b0;
                r_hit     <= 1'b0;
                r_free_ok <= 1'b0;
            end
            rtpa_pkg::S_SEARCH: begin
                if (r_idx != (rtpa_pkg::ROW_W + 1)'(rtpa_pkg::STATIONS)) begin
                    r_idx  <= r_idx + 1'b1;
                    r_pidx <= r_idx[rtpa_pkg::ROW_W-1:0];
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
                if (r_pend) begin
                    if (r_sv[r_pidx] && mac_rdata == r_in.station_mac && !r_hit) begin
                        r_hit <= 1'b1;
                        r_row <= r_pidx;
                    end
                    if (!r_sv[r_pidx] && !r_free_ok) begin
                        r_free_ok  <= 1'b1;
                        r_free_row <= r_pidx;
                    end
                end
            end
            rtpa_pkg::S_DISPATCH: begin
                r_row  <= rowsel;
                r_n    <= r_cnt[rowsel];
                r_oq   <= r_old[rowsel];
                r_j    <= '0;
                r_pend <= 1'b0;
                r_kept <= '0;
                r_m    <= -8'sd128;
                r_sum  <= '0;
                r_res  <= disp_res;
            end
            rtpa_pkg::S_ADD: begin
                r_res.found        <= r_hit;
                r_res.sample_count <= 4'(a_cnt_nx);
                r_res.status       <= rtpa_pkg::ST_OK;
            end
            rtpa_pkg::S_QMAX, rtpa_pkg::S_QSUM, rtpa_pkg::S_PSCAN: begin
                if (scan_more) begin
                    r_j    <= r_j + 1'b1;
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
                if (r_pend) begin
                    if (r_state == rtpa_pkg::S_QMAX) begin
                        if (rd_s.rssi > r_m) r_m <= rd_s.rssi;
                    end else if (r_state == rtpa_pkg::S_QSUM) begin
                        r_sum <= r_sum + rtpa_pkg::SUM_W'(p_val);
                    end else if (rd_s.expiry > r_in.present_time) begin
                        r_buf[r_kept[rtpa_pkg::SLOT_W-1:0]] <= rd_s;
                        r_kept <= r_kept + 1'b1;
                    end
                end
                if (scan_end) begin
                    r_j <= '0;
                end
            end
            rtpa_pkg::S_QWAIT: begin
                if (avg_rsp.done) begin
                    r_res.found          <= 1'b1;
                    r_res.average_dbm_q4 <= avg_rsp.avg;
                    r_res.sample_count   <= 4'(r_n);
                    r_res.status         <= rtpa_pkg::ST_OK;
                end
            end
            rtpa_pkg::S_PWRITE: begin
                if (r_j < r_kept) begin
                    r_j <= r_j + 1'b1;
                end else begin
                    r_res.found        <= 1'b1;
                    r_res.sample_count <= 4'(r_kept);
                    r_res.status       <= rtpa_pkg::ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/rtpa_check.sv
// port level checks for the rssi table power average block
`default_nettype none

module rtpa_check (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_ready,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire rtpa_pkg::t_out o_out_data
);

    // one step at a time
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken twice in a row");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_avg_ok_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != rtpa_pkg::ST_OK) |->
        (o_out_data.average_dbm_q4 == '0))
        else $error("average on a failed step");

    a_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == rtpa_pkg::ST_UNKNOWN ||
                         o_out_data.status == rtpa_pkg::ST_FULL)) |->
        (!o_out_data.found && o_out_data.sample_count == '0))
        else $error("missing station reported with samples");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.sample_count <= 4'(rtpa_pkg::SAMPLES) &&
                         o_out_data.average_dbm_q4 <= 0))
        else $error("result out of range");

endmodule

bind rssi_table_power_average rtpa_check u_rtpa_check (.*);

`default_nettype wire

>>> bench/rssi_table_power_average_tb.sv
// testbench for rssi_table_power_average: directed and randomized beats checked against a local predictor
`default_nettype none

module rssi_table_power_average_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM   = 1000;
    localparam int QUIET_TAIL = 150;
    localparam int CYCLE_CAP  = 2000000;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_ready;
    rtpa_pkg::t_in  in_data;
    logic out_valid;
    logic out_ready;
    rtpa_pkg::t_out out_data;

    rssi_table_power_average u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // predictor copy of the station table and sample store
    logic [rtpa_pkg::MAC_W-1:0]  tbl_mac    [rtpa_pkg::STATIONS];
    logic                        tbl_used   [rtpa_pkg::STATIONS];
    logic [rtpa_pkg::RSSI_W-1:0] smp_rssi   [rtpa_pkg::STATIONS*rtpa_pkg::SAMPLES];
    logic [rtpa_pkg::TIME_W-1:0] smp_expiry [rtpa_pkg::STATIONS*rtpa_pkg::SAMPLES];
    logic                        smp_used   [rtpa_pkg::STATIONS*rtpa_pkg::SAMPLES];
    int unsigned                 ring_head  [rtpa_pkg::STATIONS];

    rtpa_pkg::t_in  pending_beats[$];
    rtpa_pkg::t_out expected_results[$];
    int   error_count;
    int   cycle_count;
    int   beats_left;
    logic [rtpa_pkg::MAC_W-1:0] mac_pool[16];

    const longint unsigned POW10[10] = '{1048576, 832914, 661607, 525533, 417446,
                                         331589, 263390, 209218, 166188, 132008};

    function automatic int find_station(logic [rtpa_pkg::MAC_W-1:0] mac);
        for (int s = 0; s < rtpa_pkg::STATIONS; s++)
            if (tbl_used[s] && tbl_mac[s] == mac) return s;
        return -1;
    endfunction

    function automatic int unsigned held_samples(int s);
        int unsigned n;
        n = 0;
        for (int j = 0; j < rtpa_pkg::SAMPLES; j++) n += smp_used[s*rtpa_pkg::SAMPLES+j];
        return n;
    endfunction

    function automatic int unsigned ring_slot(int s, int unsigned j);
        return s*rtpa_pkg::SAMPLES + (ring_head[s] + j) % rtpa_pkg::SAMPLES;
    endfunction

    function automatic int power_mean_q4(int s, int unsigned n);
        int m, r;
        int unsigned d;
        longint unsigned p, sum, v, k, y, f, l, off;
        longint res;
        m = -256;
        for (int unsigned j = 0; j < n; j++) begin
            r = $signed(smp_rssi[ring_slot(s, j)]);
            if (r > m) m = r;
        end
        sum = 0;
        for (int unsigned j = 0; j < n; j++) begin
            d = m - $signed(smp_rssi[ring_slot(s, j)]);
            p = POW10[d % 10];
            for (int unsigned a = d / 10; a > 0 && p != 0; a--) p = p / 10;
            sum += p;
        end
        v = sum / n;
        if (v == 0) v = 1;
        if (v >= 2*1048576) v = 2*1048576 - 1;
        k = 0;
        while (v < 1048576) begin
            v = v << 1;
            k++;
        end
        y = v;
        f = 0;
        for (int i = 1; i <= 16; i++) begin
            y = (y * y) >> 20;
            if (y >= 2*1048576) begin
                y = y >> 1;
                f |= 64'd1 << (16 - i);
            end
        end
        l = k*65536 - f;
        off = (l * 64'd3156528 + (64'd1 << 31)) >> 32;
        res = longint'(m) * 16 - longint'(off);
        if (res > 0) res = 0;
        if (res < -2048) res = -2048;
        return int'(res);
    endfunction

    function automatic rtpa_pkg::t_out predict_step(rtpa_pkg::t_in it);
        rtpa_pkg::t_out o;
        int s;
        int unsigned n, idx, kept;
        logic [rtpa_pkg::RSSI_W-1:0] kr[rtpa_pkg::SAMPLES];
        logic [rtpa_pkg::TIME_W-1:0] ke[rtpa_pkg::SAMPLES];
        o = '0;
        s = find_station(it.station_mac);
        case (rtpa_pkg::t_op'(it.opcode))
            rtpa_pkg::OP_ADD: begin
                if (s >= 0) begin
                    o.found = 1'b1;
                end else begin
                    for (int t = 0; t < rtpa_pkg::STATIONS; t++)
                        if (!tbl_used[t] && s < 0) s = t;
                    if (s >= 0) begin
                        tbl_used[s] = 1'b1;
                        tbl_mac[s] = it.station_mac;
                        ring_head[s] = 0;
                        for (int j = 0; j < rtpa_pkg::SAMPLES; j++)
                            smp_used[s*rtpa_pkg::SAMPLES+j] = 1'b0;
                    end else begin
                        o.status = rtpa_pkg::ST_FULL;
                    end
                end
                if (s >= 0) begin
                    n = held_samples(s);
                    if (n < rtpa_pkg::SAMPLES) begin
                        idx = ring_slot(s, n);
                    end else begin
                        idx = ring_slot(s, 0);
                        ring_head[s] = (ring_head[s] + 1) % rtpa_pkg::SAMPLES;
                    end
                    smp_rssi[idx] = it.rssi_dbm;
                    smp_expiry[idx] = it.expiry_time;
                    smp_used[idx] = 1'b1;
                    o.sample_count = 4'(held_samples(s));
                end
            end
            rtpa_pkg::OP_QUERY, rtpa_pkg::OP_PURGE: begin
                if (s < 0) begin
                    o.status = rtpa_pkg::ST_UNKNOWN;
                end else begin
                    o.found = 1'b1;
                    n = held_samples(s);
                    if (rtpa_pkg::t_op'(it.opcode) == rtpa_pkg::OP_QUERY) begin
                        if (n == 0) o.status = rtpa_pkg::ST_EMPTY;
                        else o.average_dbm_q4 = rtpa_pkg::AVG_W'(power_mean_q4(s, n));
                    end else begin
                        kept = 0;
                        for (int unsigned j = 0; j < n; j++) begin
                            idx = ring_slot(s, j);
                            if (smp_expiry[idx] > it.present_time) begin
                                kr[kept] = smp_rssi[idx];
                                ke[kept] = smp_expiry[idx];
                                kept++;
                            end
                        end
                        for (int unsigned j = 0; j < rtpa_pkg::SAMPLES; j++) begin
                            smp_used[s*rtpa_pkg::SAMPLES+j] = (j < kept);
                            if (j < kept) begin
                                smp_rssi[s*rtpa_pkg::SAMPLES+j] = kr[j];
                                smp_expiry[s*rtpa_pkg::SAMPLES+j] = ke[j];
                            end
                        end
                        ring_head[s] = 0;
                    end
                    o.sample_count = 4'(held_samples(s));
                end
            end
            default: o = '0;
        endcase
        return o;
    endfunction

    function automatic rtpa_pkg::t_in make_beat(rtpa_pkg::t_op op,
                                                logic [rtpa_pkg::MAC_W-1:0] mac, int rssi,
                                                logic [rtpa_pkg::TIME_W-1:0] expiry,
                                                logic [rtpa_pkg::TIME_W-1:0] now);
        rtpa_pkg::t_in it;
        it.opcode = op;
        it.station_mac = mac;
        it.rssi_dbm = rtpa_pkg::RSSI_W'(rssi);
        it.expiry_time = expiry;
        it.present_time = now;
        return it;
    endfunction

    function automatic rtpa_pkg::t_in random_beat();
        rtpa_pkg::t_in it;
        int unsigned pick;
        it.station_mac = mac_pool[$urandom_range(0, 15)];
        if ($urandom_range(0, 99) < 7) it.station_mac = 48'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 52) it.opcode = rtpa_pkg::OP_ADD;
        else if (pick < 77) it.opcode = rtpa_pkg::OP_QUERY;
        else if (pick < 96) it.opcode = rtpa_pkg::OP_PURGE;
        else it.opcode = rtpa_pkg::OP_NONE;
        if ($urandom_range(0, 9) == 0) it.rssi_dbm = rtpa_pkg::RSSI_W'($urandom);
        else it.rssi_dbm = rtpa_pkg::RSSI_W'(-int'($urandom_range(0, 128)));
        it.expiry_time = $urandom;
        it.present_time = $urandom;
        return it;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        error_count++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("simulation failed");
            $finish;
        end
    end

    // input side driver with random idle bursts
    int in_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
            in_gap   <= 0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) beats_left <= beats_left - 1;
            if (in_gap > 0) begin
                in_gap   <= in_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_beats.size() > 0 &&
                         !(beats_left > QUIET_TAIL && $urandom_range(0, 7) == 0)) begin
                in_data  <= pending_beats[0];
                expected_results.push_back(predict_step(pending_beats.pop_front()));
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
                if (beats_left > QUIET_TAIL) in_gap <= $urandom_range(0, 11);
            end
        end
    end

    // output side stalls and checking
    int out_gap;
    rtpa_pkg::t_out want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_gap   <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (out_data.found !== want.found)
                        report_mismatch("found", out_data.found, want.found);
                    if (out_data.average_dbm_q4 !== want.average_dbm_q4)
                        report_mismatch("average_dbm_q4", out_data.average_dbm_q4,
                                        want.average_dbm_q4);
                    if (out_data.sample_count !== want.sample_count)
                        report_mismatch("sample_count", out_data.sample_count,
                                        want.sample_count);
                    if (out_data.status !== want.status)
                        report_mismatch("status", out_data.status, want.status);
                end
            end
            if (out_gap > 0) begin
                out_gap   <= out_gap - 1;
                out_ready <= 1'b0;
            end else if (beats_left > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
                out_gap   <= $urandom_range(0, 11);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        error_count = 0;
        cycle_count = 0;
        for (int s = 0; s < rtpa_pkg::STATIONS; s++) begin
            tbl_used[s] = 1'b0;
            ring_head[s] = 0;
        end
        for (int j = 0; j < rtpa_pkg::STATIONS*rtpa_pkg::SAMPLES; j++) smp_used[j] = 1'b0;
        for (int i = 0; i < 16; i++) mac_pool[i] = 48'({$urandom, $urandom});

        // edge values, every opcode, overwrite, purge to empty, saturation
        pending_beats.push_back(make_beat(rtpa_pkg::OP_QUERY, 48'h0, 0, 0, 0));
        pending_beats.push_back(make_beat(rtpa_pkg::OP_PURGE, 48'hFFFF_FFFF_FFFF, -1, '1, '1));
        pending_beats.push_back(make_beat(rtpa_pkg::OP_ADD, 48'h0, 0, '1, 0));
        pending_beats.push_back(make_beat(rtpa_pkg::OP_ADD, 48'hFFFF_FFFF_FFFF, -128, 0, '1));
        pending_beats.push_back(make_beat(rtpa_pkg::OP_QUERY, 48'h0, 0, 0, 0));
        pending_beats.push_back(make_beat(rtpa_pkg::OP_QUERY, 48'hFFFF_FFFF_FFFF, 0, 0, 0));
        pending_beats.push_back(make_beat(rtpa_pkg::OP_NONE, 48'hFFFF_FFFF_FFFF, -1, '1, '1));
        for (int i = 0; i < 10; i++)
            pending_beats.push_back(make_beat(rtpa_pkg::OP_ADD, 48'h5A5A_1234_00FF, -i*9,
                                              100 + i, 0));
        pending_beats.push_back(make_beat(rtpa_pkg::OP_QUERY, 48'h5A5A_1234_00FF, 0, 0, 0));
        pending_beats.push_back(make_beat(rtpa_pkg::OP_PURGE, 48'h5A5A_1234_00FF, 0, 0, 104));
        pending_beats.push_back(make_beat(rtpa_pkg::OP_QUERY, 48'h5A5A_1234_00FF, 0, 0, 0));
        pending_beats.push_back(make_beat(rtpa_pkg::OP_PURGE, 48'h5A5A_1234_00FF, 0, 0, '1));
        pending_beats.push_back(make_beat(rtpa_pkg::OP_QUERY, 48'h5A5A_1234_00FF, 0, 0, 0));
        pending_beats.push_back(make_beat(rtpa_pkg::OP_ADD, 48'h0, 127, 5, 0));
        pending_beats.push_back(make_beat(rtpa_pkg::OP_ADD, 48'h0, -128, 5, 0));
        pending_beats.push_back(make_beat(rtpa_pkg::OP_QUERY, 48'h0, 0, 0, 0));
        for (int i = 0; i < N_RANDOM; i++) pending_beats.push_back(random_beat());
        beats_left = pending_beats.size();

        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
